// ===== design/wsd_pkg.sv =====
// Shared constants and types for the WebSocket frame deframer.
package wsd_pkg;

   localparam int LENGTH_BITS = 64;

   typedef logic [LENGTH_BITS-1:0] length_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] payload_byte;
      logic [1:0] message_type;
      logic       message_last;
   } rsp_item_type;

endpackage

// ===== design/wsd_parser.sv =====
// Frame header parser, payload unmasking and event generation, one word per accept.
module wsd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   output logic                 ev_valid,
   output wsd_pkg::rsp_item_type ev
);
   import wsd_pkg::*;

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_LEN7    = 3'd1;
   localparam logic [2:0] PH_EXT     = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [2:0] EV_DATA  = 3'd0;
   localparam logic [2:0] EV_EMPTY = 3'd1;
   localparam logic [2:0] EV_CLOSE = 3'd2;
   localparam logic [2:0] EV_PING  = 3'd3;
   localparam logic [2:0] EV_PONG  = 3'd4;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   logic [2:0]  phase_ff, phase_in;
   logic        final_ff, final_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   length_type  remain_ff, remain_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic [3:0]  frag_type_ff, frag_type_in;
   logic        closed_ff, closed_in;

   logic [3:0]   eff_type;
   logic         fe_valid;
   rsp_item_type fe_item;
   logic         fe_close;
   logic [6:0]   len7;
   logic [7:0]   unmasked;
   logic         last_byte;

   assign eff_type = (opcode_ff != 4'h0) ? opcode_ff : frag_type_ff;
   assign len7     = in_byte[6:0];
   assign unmasked = masked_ff ? (in_byte ^ mask_key_ff[{~mask_pos_ff, 3'b000} +: 8]) : in_byte;
   assign last_byte = (remain_ff == LENGTH_BITS'(1));

   // event for a frame that ends without forwarded payload
   always_comb begin
      fe_valid = 1'b0;
      fe_item  = '0;
      fe_close = 1'b0;
      if (final_ff) begin
         case (eff_type)
            OP_TEXT, OP_BINARY: begin
               fe_valid = 1'b1;
               fe_item.event_kind   = EV_EMPTY;
               fe_item.message_type = eff_type[1:0];
               fe_item.message_last = 1'b1;
            end
            OP_CLOSE: begin
               fe_valid = 1'b1;
               fe_close = 1'b1;
               fe_item.event_kind = EV_CLOSE;
            end
            OP_PING: begin
               fe_valid = 1'b1;
               fe_item.event_kind = EV_PING;
            end
            OP_PONG: begin
               fe_valid = 1'b1;
               fe_item.event_kind = EV_PONG;
            end
            default: fe_valid = 1'b0;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      final_in     = final_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      remain_in    = remain_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      mask_key_in  = mask_key_ff;
      mask_pos_in  = mask_pos_ff;
      frag_type_in = frag_type_ff;
      closed_in    = closed_ff;
      ev_valid     = 1'b0;
      ev           = '0;
      if (!closed_ff) begin
         case (phase_ff)
            PH_LEN7: begin
               masked_in = in_byte[7];
               remain_in = '0;
               if (len7 == LEN_EXT16) begin
                  hdr_cnt_in = EXT16_BYTES;
                  phase_in   = PH_EXT;
               end else if (len7 == LEN_EXT64) begin
                  hdr_cnt_in = EXT64_BYTES;
                  phase_in   = PH_EXT;
               end else begin
                  remain_in   = LENGTH_BITS'(len7);
                  mask_pos_in = 2'd0;
                  if (in_byte[7]) begin
                     phase_in = PH_KEY;
                  end else if (len7 == 7'd0) begin
                     phase_in  = PH_HDR0;
                     ev_valid  = fe_valid;
                     ev        = fe_item;
                     closed_in = fe_close;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_EXT: begin
               remain_in  = {remain_ff[LENGTH_BITS-9:0], in_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               if (hdr_cnt_ff == 4'd1) begin
                  mask_pos_in = 2'd0;
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                  end else if (remain_in == '0) begin
                     phase_in  = PH_HDR0;
                     ev_valid  = fe_valid;
                     ev        = fe_item;
                     closed_in = fe_close;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_KEY: begin
               mask_key_in = {mask_key_ff[23:0], in_byte};
               mask_pos_in = mask_pos_ff + 2'd1;
               if (mask_pos_ff == 2'd3) begin
                  if (remain_ff == '0) begin
                     phase_in  = PH_HDR0;
                     ev_valid  = fe_valid;
                     ev        = fe_item;
                     closed_in = fe_close;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               mask_pos_in = mask_pos_ff + 2'd1;
               remain_in   = remain_ff - LENGTH_BITS'(1);
               if (last_byte) begin
                  phase_in = PH_HDR0;
               end
               if (eff_type inside {OP_TEXT, OP_BINARY}) begin
                  ev_valid = 1'b1;
                  ev.event_kind   = EV_DATA;
                  ev.payload_byte = unmasked;
                  ev.message_type = eff_type[1:0];
                  ev.message_last = last_byte & final_ff;
               end else if (last_byte) begin
                  ev_valid  = fe_valid;
                  ev        = fe_item;
                  closed_in = fe_close;
               end
            end
            default: begin
               final_in  = in_byte[7];
               opcode_in = in_byte[3:0];
               if (!in_byte[7] && in_byte[3:0] != 4'h0) begin
                  frag_type_in = in_byte[3:0];
               end
               phase_in = PH_LEN7;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         final_ff     <= 1'b0;
         opcode_ff    <= 4'h0;
         masked_ff    <= 1'b0;
         remain_ff    <= '0;
         hdr_cnt_ff   <= 4'd0;
         mask_key_ff  <= '0;
         mask_pos_ff  <= 2'd0;
         frag_type_ff <= 4'h0;
         closed_ff    <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         final_ff     <= final_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         remain_ff    <= remain_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         mask_key_ff  <= mask_key_in;
         mask_pos_ff  <= mask_pos_in;
         frag_type_ff <= frag_type_in;
         closed_ff    <= closed_in;
      end
   end

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("link closed flag cleared without reset");

   a_no_event_closed: assert property (@(posedge clock) disable iff (reset)
      ev_valid |-> !closed_ff)
      else $error("event raised after close");

   a_payload_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != '0))
      else $error("payload phase with no bytes remaining");

endmodule

// ===== design/wsd_out_stage.sv =====
// Output register with skid entry for the result channel.
module wsd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  wsd_pkg::rsp_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wsd_pkg::rsp_item_type out_item
);
   import wsd_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         push, pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_item;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = in_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while output register empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> !skid_valid_ff)
      else $error("skid entry not moved on pop");

endmodule

// ===== design/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket receive-side frame deframer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_in_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_event_kind, rsp_payload_byte,
//                                            rsp_message_type, rsp_message_last
//
// One word is parsed per cycle while req_ready is high; its event, if any, is registered in the output stage.
// Throughput is one word per clock while req_ready is high; the header/length/unmask update is combinational.
// Synchronous active-high reset returns the parser to the first header byte.
// req_ready drops only while the skid entry holds a stalled event.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_message_type,
   output logic       rsp_message_last
);
   import wsd_pkg::*;

   logic         step;
   logic         ev_valid;
   rsp_item_type ev;
   rsp_item_type rsp_item;

   assign step = req_valid && req_ready;

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (req_in_byte),
      .ev_valid(ev_valid),
      .ev      (ev)
   );

   wsd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (step && ev_valid),
      .in_ready (req_ready),
      .in_item  (ev),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_item (rsp_item)
   );

   assign rsp_event_kind   = rsp_item.event_kind;
   assign rsp_payload_byte = rsp_item.payload_byte;
   assign rsp_message_type = rsp_item.message_type;
   assign rsp_message_last = rsp_item.message_last;

endmodule

// ===== test/tb_websocket_frame_deframer_top.sv =====
// Self-checking testbench for the WebSocket frame deframer top level.
module tb_websocket_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   typedef enum logic [3:0] {
      OP_CONT   = 4'h0,
      OP_TEXT   = 4'h1,
      OP_BINARY = 4'h2,
      OP_CLOSE  = 4'h8,
      OP_PING   = 4'h9,
      OP_PONG   = 4'hA
   } opcode_e;

   typedef enum logic [2:0] {
      EV_DATA      = 3'd0,
      EV_EMPTY_END = 3'd1,
      EV_CLOSE     = 3'd2,
      EV_PING      = 3'd3,
      EV_PONG      = 3'd4
   } event_e;

   typedef enum logic [2:0] {
      PH_HEAD0  = 3'd0,
      PH_HEAD1  = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_MASK   = 3'd3,
      PH_DATA   = 3'd4
   } phase_e;

   localparam logic [6:0] LEN16_MARK  = 7'd126;
   localparam logic [6:0] LEN64_MARK  = 7'd127;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PRINT_CAP   = 40;
   localparam int         PHASE_WORDS = 455;

   class deframe_scoreboard;
      rsp_item_type pending_events[$];
      int           errors;
      int           events_seen;
      int           words_seen;
      phase_e       phase;
      bit           fin;
      logic [3:0]   opcode;
      logic [3:0]   frag_type;
      bit           masked;
      length_type   remaining;
      logic [3:0]   ext_left;
      logic [31:0]  key;
      logic [1:0]   key_pos;
      bit           closed;

      function new();
         phase     = PH_HEAD0;
         fin       = 1'b0;
         opcode    = OP_CONT;
         frag_type = OP_CONT;
         masked    = 1'b0;
         remaining = '0;
         ext_left  = '0;
         key       = '0;
         key_pos   = '0;
         closed    = 1'b0;
      endfunction

      function logic [3:0] message_kind();
         return (opcode != OP_CONT) ? opcode : frag_type;
      endfunction

      function void push(event_e kind, logic [7:0] data, logic [1:0] mtype, bit last);
         rsp_item_type item;
         item.event_kind   = kind;
         item.payload_byte = data;
         item.message_type = mtype;
         item.message_last = last;
         pending_events = {pending_events, item};
      endfunction

      function void end_of_frame();
         logic [3:0] t;
         t = message_kind();
         if (!fin) return;
         case (t)
            OP_TEXT, OP_BINARY: push(EV_EMPTY_END, 8'h00, t[1:0], 1'b1);
            OP_CLOSE: begin
               closed = 1'b1;
               push(EV_CLOSE, 8'h00, 2'd0, 1'b0);
            end
            OP_PING: push(EV_PING, 8'h00, 2'd0, 1'b0);
            OP_PONG: push(EV_PONG, 8'h00, 2'd0, 1'b0);
            default: ;
         endcase
      endfunction

      function void header_done();
         key_pos = '0;
         if (remaining == '0) begin
            phase = PH_HEAD0;
            end_of_frame();
         end else begin
            phase = PH_DATA;
         end
      endfunction

      function void length_done();
         if (masked) begin
            phase   = PH_MASK;
            key_pos = '0;
         end else begin
            header_done();
         end
      endfunction

      function void note_word(logic [7:0] b);
         logic [3:0] t;
         logic [7:0] v;
         logic [6:0] len7;
         words_seen++;
         if (closed) return;
         case (phase)
            PH_HEAD1: begin
               len7      = b[6:0];
               masked    = b[7];
               remaining = '0;
               if (len7 == LEN16_MARK) begin
                  ext_left = 4'd2;
                  phase    = PH_EXTLEN;
               end else if (len7 == LEN64_MARK) begin
                  ext_left = 4'd8;
                  phase    = PH_EXTLEN;
               end else begin
                  remaining = length_type'(len7);
                  length_done();
               end
            end
            PH_EXTLEN: begin
               remaining = {remaining[LENGTH_BITS-9:0], b};
               ext_left  = ext_left - 4'd1;
               if (ext_left == 4'd0) length_done();
            end
            PH_MASK: begin
               key     = {key[23:0], b};
               key_pos = key_pos + 2'd1;
               if (key_pos == 2'd0) header_done();
            end
            PH_DATA: begin
               t = message_kind();
               v = masked ? (b ^ key[8*(3-key_pos) +: 8]) : b;
               key_pos   = key_pos + 2'd1;
               remaining = remaining - 1'b1;
               if (remaining == '0) phase = PH_HEAD0;
               if (t == OP_TEXT || t == OP_BINARY)
                  push(EV_DATA, v, t[1:0], (remaining == '0) && fin);
               else if (remaining == '0)
                  end_of_frame();
            end
            default: begin
               fin    = b[7];
               opcode = b[3:0];
               if (!fin && opcode != OP_CONT) frag_type = opcode;
               phase = PH_HEAD1;
            end
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_event(rsp_item_type got);
         rsp_item_type want;
         events_seen++;
         if (pending_events.size() == 0) begin
            report($sformatf("event kind %0d with none pending", got.event_kind));
            return;
         end
         want = pending_events.pop_front();
         if (got.event_kind !== want.event_kind)
            report($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
         if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %02h, want %02h", got.payload_byte,
                             want.payload_byte));
         if (got.message_type !== want.message_type)
            report($sformatf("message_type %0d, want %0d", got.message_type,
                             want.message_type));
         if (got.message_last !== want.message_last)
            report($sformatf("message_last %0d, want %0d", got.message_last,
                             want.message_last));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_payload_byte;
   logic [1:0] rsp_message_type;
   logic       rsp_message_last;

   deframe_scoreboard sb;
   int                idle_pct;
   int                stall_pct;
   int                words_sent;
   int                cycles;

   websocket_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_message_type (rsp_message_type),
      .rsp_message_last (rsp_message_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_websocket_frame_deframer_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_word(req_in_byte);
         if (rsp_valid && rsp_ready)
            sb.check_event({rsp_event_kind, rsp_payload_byte, rsp_message_type,
                            rsp_message_last});
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [7:0] head_byte(bit fin, logic [2:0] rsv, logic [3:0] op);
      return {fin, rsv, op};
   endfunction

   // Hold the word until accepted; return at the following falling edge.
   task automatic send_word(logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(bit fin, logic [3:0] op, int max_len);
      int          len;
      int          form;
      int          r;
      bit          masked;
      logic [63:0] len64;
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 75) len = $urandom_range(12, 1);
      else if (r < 93) len = $urandom_range(125, 13);
      else len = $urandom_range(300, 126);
      if (len > max_len) len = max_len;
      r = $urandom_range(99);
      if (len > 125) form = $urandom_range(2, 1);
      else if (r < 82) form = 0;
      else if (r < 91) form = 1;
      else form = 2;
      masked = 1'($urandom_range(1));
      len64  = 64'(len);
      send_word(head_byte(fin, 3'($urandom_range(7)), op));
      case (form)
         0: send_word({masked, len64[6:0]});
         1: begin
            send_word({masked, LEN16_MARK});
            send_word(len64[15:8]);
            send_word(len64[7:0]);
         end
         default: begin
            send_word({masked, LEN64_MARK});
            for (int i = 7; i >= 0; i--) send_word(len64[8*i +: 8]);
         end
      endcase
      if (masked) repeat (4) send_word(8'($urandom_range(255)));
      repeat (len) send_word(8'($urandom_range(255)));
   endtask

   task automatic send_random_message();
      int         r;
      int         frags;
      logic [3:0] op;
      r = $urandom_range(99);
      if (r < 60) begin
         frags = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1;
         op    = $urandom_range(1) ? OP_TEXT : OP_BINARY;
         for (int f = 0; f < frags; f++) begin
            send_frame(f == frags - 1, (f == 0) ? op : OP_CONT, 300);
            if (f < frags - 1 && $urandom_range(4) == 0)
               send_frame(1'b1, $urandom_range(1) ? OP_PING : OP_PONG, 125);
         end
      end else if (r < 75) begin
         send_frame(1'b1, $urandom_range(1) ? OP_PING : OP_PONG, 125);
      end else if (r < 85) begin
         send_frame(1'b0, $urandom_range(1) ? OP_PING : OP_PONG, 125);
         send_frame(1'b1, OP_CONT, 125);
      end else begin
         // stray frames: unknown opcodes, orphan continuations, unfinished messages
         op = 4'($urandom_range(15));
         if (op == OP_CLOSE) op = 4'hB;
         send_frame(1'($urandom_range(1)), op, 300);
      end
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      rsp_ready   = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
      words_sent  = 0;
      cycles      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(head_byte(1'b1, 3'b000, OP_TEXT));
      send_word(8'h01);
      send_word(8'h00);
      send_word(head_byte(1'b1, 3'b000, OP_BINARY));
      send_word(8'h82);
      repeat (5) send_word(8'hFF);
      send_word(8'h00);
      send_word(head_byte(1'b1, 3'b000, OP_TEXT));
      send_word(8'h00);
      send_word(head_byte(1'b1, 3'b000, OP_PING));
      send_word(8'h00);
      send_word(head_byte(1'b0, 3'b000, OP_BINARY));
      send_word(8'h01);
      send_word(8'hAA);
      send_word(head_byte(1'b1, 3'b000, OP_CONT));
      send_word(8'h00);
      send_word(head_byte(1'b1, 3'b111, OP_TEXT));
      send_word({1'b0, LEN16_MARK});
      send_word(8'h00);
      send_word(8'h00);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         for (int target = words_sent + PHASE_WORDS; words_sent < target; )
            send_random_message();
      end

      // close split over two frames, then trailing words that must be dropped
      send_word(head_byte(1'b0, 3'b000, OP_CLOSE));
      send_word(8'h00);
      send_word(head_byte(1'b1, 3'b000, OP_CONT));
      send_word(8'h81);
      repeat (5) send_word(8'($urandom_range(255)));
      repeat (20) send_word(8'($urandom_range(255)));
      req_valid <= 1'b0;

      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run summary: %0d words accepted, %0d events checked, %0d mismatches",
               sb.words_seen, sb.events_seen, sb.errors);
      $display("run summary: fragmented text/binary, masking, 16/64-bit lengths, control"
               , " frames, four idle/stall mixes, words after close");
      if (sb.errors == 0) begin
         $display("tb_websocket_frame_deframer_top: clean");
      end else begin
         $display("tb_websocket_frame_deframer_top: errors");
      end
      $finish;
   end

endmodule
